### rtl/core/tscpmd_pkg.sv
// Shared types, constants and helpers of the TSC mass deposit block.
`timescale 1ns / 1ps

package tscpmd_pkg;

  // Defaults of the top level parameters
  localparam int unsigned MAX_CELLS_DEF = 1024;
  localparam int unsigned FRAC_BITS_DEF = 14;

  // Field widths
  localparam int unsigned POS_W     = 24;
  localparam int unsigned MASS_W    = 32;
  localparam int unsigned SIZE_W    = 11;
  localparam int unsigned FLAGS_W   = 6;
  localparam int unsigned GUARD_W   = 3;
  localparam int unsigned SCALE_W   = 32;
  localparam int unsigned CELL_W    = 12;
  localparam int unsigned DENS_W    = 40;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_VAL_W = 32;

  // Weights are Q1.30, one spare bit holds the value 1.0
  localparam int unsigned W_FRAC = 30;
  localparam int unsigned W_Q_W  = W_FRAC + 1;
  // mass * density_scale, Q32.32
  localparam int unsigned MD_W   = MASS_W + SCALE_W;

  localparam int unsigned N_AXES     = 3;
  localparam logic [1:0]  TAP_LAST   = 2'd2;
  localparam int unsigned N_CONTRIB  = 27;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X        = 3'd0,
    REG_SIZE_Y        = 3'd1,
    REG_SIZE_Z        = 3'd2,
    REG_OUTFLOW_FLAGS = 3'd3,
    REG_GUARD_CELLS   = 3'd4,
    REG_DENSITY_SCALE = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_z;
    logic [MASS_W-1:0] mass;
  } particle_t;

  typedef struct packed {
    logic signed [CELL_W-1:0] cell_x;
    logic signed [CELL_W-1:0] cell_y;
    logic signed [CELL_W-1:0] cell_z;
    logic [DENS_W-1:0]        density;
    logic                     in_range;
    logic                     skipped;
    logic                     last;
  } contrib_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_VAL_W-1:0] value;
  } cfg_wr_t;

  typedef struct packed {
    logic [SIZE_W-1:0]  size_x;
    logic [SIZE_W-1:0]  size_y;
    logic [SIZE_W-1:0]  size_z;
    logic [FLAGS_W-1:0] outflow_flags;
    logic [GUARD_W-1:0] guard_cells;
    logic [SCALE_W-1:0] density_scale;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    size_x:        11'd64,
    size_y:        11'd64,
    size_z:        11'd64,
    outflow_flags: 6'd0,
    guard_cells:   3'd2,
    density_scale: 32'd65536
  };

  // One particle ready for expansion; w[axis][tap], tap 0 is cell c-1
  typedef struct packed {
    logic                                skip;
    logic [N_AXES-1:0][2:0][W_Q_W-1:0]   w;
    logic [MD_W-1:0]                     md;
  } part_t;

  // Sideband that rides along the multiply pipe
  typedef struct packed {
    logic signed [CELL_W-1:0] cell_x;
    logic signed [CELL_W-1:0] cell_y;
    logic signed [CELL_W-1:0] cell_z;
    logic                     in_range;
    logic                     skipped;
    logic                     last;
  } tag_t;

  // One contribution on its way into the multiply pipe
  typedef struct packed {
    logic [W_Q_W-1:0] wx;
    logic [W_Q_W-1:0] wy;
    logic [W_Q_W-1:0] wz;
    logic [MD_W-1:0]  md;
    tag_t             tag;
  } beat_t;

  // Size register clamped to the largest supported axis
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s,
                                                 input logic [SIZE_W-1:0] lim);
    return (s > lim) ? lim : s;
  endfunction

endpackage

### rtl/core/tscpmd_stream_if.sv
// Valid/ready stream interface used for every channel of the block.
`timescale 1ns / 1ps

interface tscpmd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/tsc_particle_mass_deposit.sv
// Top level of the TSC particle mass deposit block.
`timescale 1ns / 1ps

// Takes one particle per input beat (Q10.14 position in cell units, Q16.16
// mass) and returns its triangular-shaped-cloud density contributions as result
// beats: 27 beats in z, y, x order over cells c-1..c+1, the final one flagged
// last, or one skipped beat when the particle sits within guard_cells+1 cells
// of a face marked outflow. Each beat carries the cell index (low 12 bits of
// the exact index), an in-range flag for the grid and the Q24.16 density,
// saturated. The result channel carries one beat per cycle while its receiver
// keeps ready high, so a particle occupies 27 beats there and a skipped one a
// single beat; that 27-beat expansion in the tap sequencer limits the sustained
// particle rate. The next particle is taken in and prepared while the current
// one is still expanding. With an idle pipe the first beat is presented once
// the particle has passed two front-end stages, the sequencer register and
// eight multiply-pipe registers. Configuration writes land in the register
// file at once (ready is always high); write only while the block is idle.
module tsc_particle_mass_deposit #(
  parameter int unsigned MAX_CELLS_PER_AXIS = tscpmd_pkg::MAX_CELLS_DEF,
  parameter int unsigned FRAC_BITS          = tscpmd_pkg::FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  tscpmd_stream_if.sink    particle_i,
  tscpmd_stream_if.source  contrib_o,
  tscpmd_stream_if.sink    cfg_i
);

  localparam int unsigned CBW = tscpmd_pkg::POS_W - FRAC_BITS;

  tscpmd_pkg::cfg_t cfg_q;

  // front end to sequencer
  logic              pt_valid, pt_ready;
  tscpmd_pkg::part_t pt;
  logic [tscpmd_pkg::N_AXES-1:0][CBW-1:0] pt_cell;

  // sequencer to multiply pipe
  logic              bt_valid, bt_ready;
  tscpmd_pkg::beat_t bt;

  // Register file; unknown indexes are dropped, values masked to width
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= tscpmd_pkg::CFG_RESET;
    end else if (cfg_i.valid) begin
      unique case (tscpmd_pkg::cfg_reg_e'(cfg_i.data.index))
        tscpmd_pkg::REG_SIZE_X: begin
          cfg_q.size_x <= cfg_i.data.value[tscpmd_pkg::SIZE_W-1:0];
        end
        tscpmd_pkg::REG_SIZE_Y: begin
          cfg_q.size_y <= cfg_i.data.value[tscpmd_pkg::SIZE_W-1:0];
        end
        tscpmd_pkg::REG_SIZE_Z: begin
          cfg_q.size_z <= cfg_i.data.value[tscpmd_pkg::SIZE_W-1:0];
        end
        tscpmd_pkg::REG_OUTFLOW_FLAGS: begin
          cfg_q.outflow_flags <= cfg_i.data.value[tscpmd_pkg::FLAGS_W-1:0];
        end
        tscpmd_pkg::REG_GUARD_CELLS: begin
          cfg_q.guard_cells <= cfg_i.data.value[tscpmd_pkg::GUARD_W-1:0];
        end
        tscpmd_pkg::REG_DENSITY_SCALE: begin
          cfg_q.density_scale <= cfg_i.data.value[tscpmd_pkg::SCALE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Two stages: squares, outflow test and mass*scale, then Q1.30 weights.
  // The second stage holds the particle until its last tap, or its single skipped beat, is issued.
  tscpmd_front #(
    .MAX_CELLS_PER_AXIS (MAX_CELLS_PER_AXIS),
    .FRAC_BITS          (FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (particle_i.valid),
    .in_ready_o (particle_i.ready),
    .in_data_i  (particle_i.data),
    .pt_valid_o (pt_valid),
    .pt_ready_i (pt_ready),
    .pt_o       (pt),
    .cell_o     (pt_cell)
  );

  // One tap per cycle while the multiply pipe accepts: weight select, cell index and range test
  tscpmd_seq #(
    .MAX_CELLS_PER_AXIS (MAX_CELLS_PER_AXIS),
    .FRAC_BITS          (FRAC_BITS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .pt_valid_i (pt_valid),
    .pt_ready_o (pt_ready),
    .pt_i       (pt),
    .cell_i     (pt_cell),
    .bt_valid_o (bt_valid),
    .bt_ready_i (bt_ready),
    .bt_o       (bt)
  );

  // Seven math stages plus the output register; each stage has its own valid
  tscpmd_mul u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bt_valid_i  (bt_valid),
    .bt_ready_o  (bt_ready),
    .bt_i        (bt),
    .out_valid_o (contrib_o.valid),
    .out_ready_i (contrib_o.ready),
    .out_data_o  (contrib_o.data)
  );

endmodule

### rtl/core/tscpmd_front.sv
// Front end: outflow test, per-axis TSC weights and mass * scale, two stages.
`timescale 1ns / 1ps

module tscpmd_front #(
  parameter int unsigned MAX_CELLS_PER_AXIS = tscpmd_pkg::MAX_CELLS_DEF,
  parameter int unsigned FRAC_BITS          = tscpmd_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tscpmd_pkg::cfg_t          cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  tscpmd_pkg::particle_t     in_data_i,
  output logic                      pt_valid_o,
  input  logic                      pt_ready_i,
  output tscpmd_pkg::part_t         pt_o,
  output logic [tscpmd_pkg::N_AXES-1:0][tscpmd_pkg::POS_W-FRAC_BITS-1:0] cell_o
);

  localparam int unsigned CBW   = tscpmd_pkg::POS_W - FRAC_BITS;
  localparam int unsigned RAW_W = 2 * FRAC_BITS + 2;
  localparam int unsigned SPAN  = tscpmd_pkg::SIZE_W + FRAC_BITS;
  localparam int unsigned SKW   = ((tscpmd_pkg::POS_W > SPAN) ? tscpmd_pkg::POS_W : SPAN) + 2;
  // raw weights are in units of 2^-(2F+1); shift to Q1.30
  localparam int         E_SH   = int'(tscpmd_pkg::W_FRAC) - int'(2 * FRAC_BITS + 1);
  localparam int         L_SH   = (E_SH > 0) ? E_SH : 0;
  localparam int         R_SH   = (E_SH < 0) ? -E_SH : 0;
  localparam logic [63:0] RND   = (64'd1 << R_SH) >> 1;

  function automatic logic [tscpmd_pkg::W_Q_W-1:0] to_q30(input logic [RAW_W-1:0] w);
    logic [63:0] x;
    x = ((64'(w) << L_SH) + RND) >> R_SH;
    return x[tscpmd_pkg::W_Q_W-1:0];
  endfunction

  // stage 1
  logic                                  f1_v_q;
  logic                                  f1_skip_q, f1_skip_d;
  logic [tscpmd_pkg::N_AXES-1:0][RAW_W-1:0] f1_sq0_q, f1_sq0_d;
  logic [tscpmd_pkg::N_AXES-1:0][RAW_W-1:0] f1_sq2_q, f1_sq2_d;
  logic [tscpmd_pkg::N_AXES-1:0][CBW-1:0]   f1_cell_q, f1_cell_d;
  logic [tscpmd_pkg::MD_W-1:0]           f1_md_q, f1_md_d;
  // stage 2, holds the particle during expansion
  logic                                  pt_v_q;
  tscpmd_pkg::part_t                     pt_q, pt_d;
  logic [tscpmd_pkg::N_AXES-1:0][CBW-1:0]   cell_q;

  logic f1_load, pt_load;

  logic [tscpmd_pkg::N_AXES-1:0][tscpmd_pkg::POS_W-1:0]  pos;
  logic [tscpmd_pkg::N_AXES-1:0][tscpmd_pkg::SIZE_W-1:0] sz;
  logic [SKW-1:0] margin;

  assign pos = {in_data_i.pos_z, in_data_i.pos_y, in_data_i.pos_x};
  assign sz  = {cfg_i.size_z, cfg_i.size_y, cfg_i.size_x};

  assign pt_load    = !pt_v_q || pt_ready_i;
  assign f1_load    = !f1_v_q || pt_load;
  assign in_ready_o = f1_load;

  always_comb begin
    logic [FRAC_BITS-1:0]            t;
    logic [FRAC_BITS:0]              om;
    logic [tscpmd_pkg::SIZE_W-1:0]   s_eff;
    logic [SKW-1:0]                  p_ext;
    logic [SKW-1:0]                  lim;
    f1_skip_d = 1'b0;
    margin    = (SKW'(cfg_i.guard_cells) + SKW'(1)) << FRAC_BITS;
    for (int a = 0; a < int'(tscpmd_pkg::N_AXES); a++) begin
      t  = pos[a][FRAC_BITS-1:0];
      om = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, t};
      f1_sq2_d[a]  = RAW_W'(t) * RAW_W'(t);
      f1_sq0_d[a]  = RAW_W'(om) * RAW_W'(om);
      f1_cell_d[a] = pos[a][tscpmd_pkg::POS_W-1:FRAC_BITS];
      s_eff = tscpmd_pkg::eff_size(sz[a], tscpmd_pkg::SIZE_W'(MAX_CELLS_PER_AXIS));
      p_ext = SKW'(pos[a]);
      lim   = SKW'(s_eff) << FRAC_BITS;
      // low face: pos < margin; high face: pos > size - margin
      if (cfg_i.outflow_flags[2*a] && (p_ext < margin)) begin
        f1_skip_d = 1'b1;
      end
      if (cfg_i.outflow_flags[2*a+1] && ((p_ext + margin) > lim)) begin
        f1_skip_d = 1'b1;
      end
    end
    f1_md_d = 64'(in_data_i.mass) * 64'(cfg_i.density_scale);
  end

  always_comb begin
    logic [RAW_W-1:0] w1;
    pt_d.skip = f1_skip_q;
    pt_d.md   = f1_md_q;
    for (int a = 0; a < int'(tscpmd_pkg::N_AXES); a++) begin
      w1 = (RAW_W'(2) << (2 * FRAC_BITS)) - f1_sq0_q[a] - f1_sq2_q[a];
      pt_d.w[a][0] = to_q30(f1_sq0_q[a]);
      pt_d.w[a][1] = to_q30(w1);
      pt_d.w[a][2] = to_q30(f1_sq2_q[a]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      pt_v_q <= 1'b0;
    end else begin
      if (f1_load) begin
        f1_v_q <= in_valid_i;
      end
      if (pt_load) begin
        pt_v_q <= f1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (f1_load) begin
      f1_skip_q <= f1_skip_d;
      f1_sq0_q  <= f1_sq0_d;
      f1_sq2_q  <= f1_sq2_d;
      f1_cell_q <= f1_cell_d;
      f1_md_q   <= f1_md_d;
    end
    if (pt_load) begin
      pt_q   <= pt_d;
      cell_q <= f1_cell_q;
    end
  end

  assign pt_valid_o = pt_v_q;
  assign pt_o       = pt_q;
  assign cell_o     = cell_q;

endmodule

### rtl/core/tscpmd_seq.sv
// Sequencer: walks the 27 taps of one particle, z outer, x inner.
`timescale 1ns / 1ps

module tscpmd_seq #(
  parameter int unsigned MAX_CELLS_PER_AXIS = tscpmd_pkg::MAX_CELLS_DEF,
  parameter int unsigned FRAC_BITS          = tscpmd_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tscpmd_pkg::cfg_t      cfg_i,
  input  logic                  pt_valid_i,
  output logic                  pt_ready_o,
  input  tscpmd_pkg::part_t     pt_i,
  input  logic [tscpmd_pkg::N_AXES-1:0][tscpmd_pkg::POS_W-FRAC_BITS-1:0] cell_i,
  output logic                  bt_valid_o,
  input  logic                  bt_ready_i,
  output tscpmd_pkg::beat_t     bt_o
);

  localparam int unsigned CBW = tscpmd_pkg::POS_W - FRAC_BITS;
  localparam int unsigned XW  = ((CBW + 2) > tscpmd_pkg::CELL_W) ? CBW + 2 : tscpmd_pkg::CELL_W;

  logic [tscpmd_pkg::N_AXES-1:0][1:0] tap_q, tap_d;
  logic                               bt_v_q;
  tscpmd_pkg::beat_t                  bt_q, bt_d;

  logic s_load, issue, last_tap;
  logic [tscpmd_pkg::N_AXES-1:0][tscpmd_pkg::SIZE_W-1:0] sz;
  logic [tscpmd_pkg::N_AXES-1:0][tscpmd_pkg::CELL_W-1:0] cell_idx;
  logic [tscpmd_pkg::N_AXES-1:0]                         inr;

  assign sz       = {cfg_i.size_z, cfg_i.size_y, cfg_i.size_x};
  assign s_load   = !bt_v_q || bt_ready_i;
  assign issue    = pt_valid_i && s_load;
  assign last_tap = (tap_q[0] == tscpmd_pkg::TAP_LAST) && (tap_q[1] == tscpmd_pkg::TAP_LAST)
                 && (tap_q[2] == tscpmd_pkg::TAP_LAST);
  assign pt_ready_o = issue && (pt_i.skip || last_tap);

  // exact index c + tap - 1, range test on the exact value
  always_comb begin
    logic [XW-1:0] x;
    for (int a = 0; a < int'(tscpmd_pkg::N_AXES); a++) begin
      x = XW'(cell_i[a]) + XW'(tap_q[a]) - XW'(1);
      cell_idx[a] = x[tscpmd_pkg::CELL_W-1:0];
      inr[a]  = !x[XW-1] && (x < XW'(tscpmd_pkg::eff_size(sz[a],
                                       tscpmd_pkg::SIZE_W'(MAX_CELLS_PER_AXIS))));
    end
  end

  always_comb begin
    bt_d.wx           = pt_i.w[0][tap_q[0]];
    bt_d.wy           = pt_i.w[1][tap_q[1]];
    bt_d.wz           = pt_i.w[2][tap_q[2]];
    bt_d.md           = pt_i.md;
    bt_d.tag.cell_x   = cell_idx[0];
    bt_d.tag.cell_y   = cell_idx[1];
    bt_d.tag.cell_z   = cell_idx[2];
    bt_d.tag.in_range = &inr;
    bt_d.tag.skipped  = 1'b0;
    bt_d.tag.last     = last_tap;
    if (pt_i.skip) begin
      // rejected particle: single zero beat
      bt_d.wx  = '0;
      bt_d.wy  = '0;
      bt_d.wz  = '0;
      bt_d.md  = '0;
      bt_d.tag = '{cell_x: '0, cell_y: '0, cell_z: '0,
                   in_range: 1'b0, skipped: 1'b1, last: 1'b1};
    end
  end

  always_comb begin
    tap_d = tap_q;
    if (issue) begin
      if (pt_i.skip || last_tap) begin
        tap_d = '0;
      end else if (tap_q[0] != tscpmd_pkg::TAP_LAST) begin
        tap_d[0] = tap_q[0] + 2'd1;
      end else begin
        tap_d[0] = '0;
        if (tap_q[1] != tscpmd_pkg::TAP_LAST) begin
          tap_d[1] = tap_q[1] + 2'd1;
        end else begin
          tap_d[1] = '0;
          tap_d[2] = tap_q[2] + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q  <= '0;
      bt_v_q <= 1'b0;
    end else begin
      tap_q <= tap_d;
      if (s_load) begin
        bt_v_q <= pt_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_load) begin
      bt_q <= bt_d;
    end
  end

  assign bt_valid_o = bt_v_q;
  assign bt_o       = bt_q;

endmodule

### rtl/core/tscpmd_mul.sv
// Multiply pipe: Wx*Wy, *Wz, *mass*scale with rounding, saturation, output register.
`timescale 1ns / 1ps

module tscpmd_mul (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  bt_valid_i,
  output logic                  bt_ready_o,
  input  tscpmd_pkg::beat_t     bt_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output tscpmd_pkg::contrib_t  out_data_o
);

  localparam int unsigned NST   = 8;  // seven math stages plus the output register
  localparam int unsigned WQ    = tscpmd_pkg::W_Q_W;
  localparam int unsigned WF    = tscpmd_pkg::W_FRAC;
  localparam int unsigned PW    = 2 * WQ;
  localparam int unsigned HW    = tscpmd_pkg::MD_W / 2;
  localparam int unsigned P01_W = HW + WQ;
  localparam int unsigned MD_W  = tscpmd_pkg::MD_W;
  // product is Q32.62 split in halves; the high half is Q32.30, final result Q24.16
  localparam int unsigned R_SH  = WF - 16;
  localparam int unsigned R_W   = MD_W - R_SH;
  localparam int unsigned DW    = tscpmd_pkg::DENS_W;

  logic [NST-1:0] v_q;
  logic [NST-1:0] rdy;
  tscpmd_pkg::tag_t tag_q [NST];

  logic [PW-1:0]    s0_pxy_q;
  logic [WQ-1:0]    s0_wz_q;
  logic [MD_W-1:0]  s0_md_q;
  logic [WQ-1:0]    s1_wxy_q;
  logic [WQ-1:0]    s1_wz_q;
  logic [MD_W-1:0]  s1_md_q;
  logic [PW-1:0]    s2_pxyz_q;
  logic [MD_W-1:0]  s2_md_q;
  logic [WQ-1:0]    s3_wxyz_q;
  logic [MD_W-1:0]  s3_md_q;
  logic [P01_W-1:0] s4_p0_q, s4_p1_q;
  logic [MD_W-1:0]  s5_low_q;
  logic [P01_W-1:0] s5_p1_q;
  logic [R_W-1:0]   s6_r_q;
  logic [DW-1:0]    s7_dens_q;

  logic [PW:0]     xy_sum, xyz_sum;
  logic [MD_W-1:0] hi_sum;

  always_comb begin
    rdy[NST-1] = !v_q[NST-1] || out_ready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end
  assign bt_ready_o = rdy[0];

  // round half up from Q2.60 back to Q1.30
  assign xy_sum  = (PW + 1)'(s0_pxy_q) + ((PW + 1)'(1) << (WF - 1));
  assign xyz_sum = (PW + 1)'(s2_pxyz_q) + ((PW + 1)'(1) << (WF - 1));
  assign hi_sum  = MD_W'(s5_p1_q) + MD_W'(s5_low_q[MD_W-1:HW]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= bt_valid_i;
      end
      for (int k = 1; k < int'(NST); k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      tag_q[0] <= bt_i.tag;
      s0_pxy_q <= PW'(bt_i.wx) * PW'(bt_i.wy);
      s0_wz_q  <= bt_i.wz;
      s0_md_q  <= bt_i.md;
    end
    for (int k = 1; k < int'(NST); k++) begin
      if (rdy[k]) begin
        tag_q[k] <= tag_q[k-1];
      end
    end
    if (rdy[1]) begin
      s1_wxy_q <= xy_sum[WF+WQ-1:WF];
      s1_wz_q  <= s0_wz_q;
      s1_md_q  <= s0_md_q;
    end
    if (rdy[2]) begin
      s2_pxyz_q <= PW'(s1_wxy_q) * PW'(s1_wz_q);
      s2_md_q   <= s1_md_q;
    end
    if (rdy[3]) begin
      s3_wxyz_q <= xyz_sum[WF+WQ-1:WF];
      s3_md_q   <= s2_md_q;
    end
    if (rdy[4]) begin
      s4_p0_q <= P01_W'(s3_md_q[HW-1:0]) * P01_W'(s3_wxyz_q);
      s4_p1_q <= P01_W'(s3_md_q[MD_W-1:HW]) * P01_W'(s3_wxyz_q);
    end
    if (rdy[5]) begin
      // rounding bit of the final shift, in the low half
      s5_low_q <= MD_W'(s4_p0_q) + (MD_W'(1) << (HW + R_SH - 1));
      s5_p1_q  <= s4_p1_q;
    end
    if (rdy[6]) begin
      s6_r_q <= hi_sum[MD_W-1:R_SH];
    end
    if (rdy[7]) begin
      s7_dens_q <= (|s6_r_q[R_W-1:DW]) ? {DW{1'b1}} : s6_r_q[DW-1:0];
    end
  end

  assign out_valid_o         = v_q[NST-1];
  assign out_data_o.cell_x   = tag_q[NST-1].cell_x;
  assign out_data_o.cell_y   = tag_q[NST-1].cell_y;
  assign out_data_o.cell_z   = tag_q[NST-1].cell_z;
  assign out_data_o.density  = s7_dens_q;
  assign out_data_o.in_range = tag_q[NST-1].in_range;
  assign out_data_o.skipped  = tag_q[NST-1].skipped;
  assign out_data_o.last     = tag_q[NST-1].last;

endmodule

### rtl/core/tscpmd_checker.sv
// Port-level checks of the TSC mass deposit block and their bind.
`timescale 1ns / 1ps

module tscpmd_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input tscpmd_pkg::contrib_t out_data_i
);

  logic       in_acc, out_acc;
  logic [7:0] pend_q, pend_d;
  logic [4:0] beat_q, beat_d;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // particles accepted whose last beat is not yet out
  always_comb begin
    pend_d = pend_q + {7'd0, in_acc} - {7'd0, out_acc && out_data_i.last};
    beat_d = beat_q;
    if (out_acc) begin
      beat_d = out_data_i.last ? 5'd0 : beat_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      beat_q <= '0;
    end else begin
      pend_q <= pend_d;
      beat_q <= beat_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result beat dropped or changed while stalled");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !out_data_i.skipped
      |-> out_data_i.last == (beat_q == 5'(tscpmd_pkg::N_CONTRIB - 1)))
    else $error("last flag not on the 27th contribution");

  a_skip_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_data_i.skipped
      |-> out_data_i.last && beat_q == 5'd0 && out_data_i.density == '0
          && !out_data_i.in_range)
    else $error("malformed skipped beat");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pend_q != 8'd0)
    else $error("result beat without an outstanding particle");

endmodule

bind tsc_particle_mass_deposit tscpmd_checker u_tscpmd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (particle_i.valid),
  .in_ready_i  (particle_i.ready),
  .out_valid_i (contrib_o.valid),
  .out_ready_i (contrib_o.ready),
  .out_data_i  (contrib_o.data)
);
